### hdl/lpd_pkg.sv
// Package: shared types and constants of the length-prefix deframer.
package lpd_pkg;

    localparam int unsigned LENGTH_BYTES_DEF = 4;
    localparam logic [31:0] MAX_LENGTH_RESET = 32'd65536;

    typedef enum logic [2:0] {
        KIND_HEADER  = 3'd0,
        KIND_PAYLOAD = 3'd1,
        KIND_EMPTY   = 3'd2,
        KIND_ERROR   = 3'd3,
        KIND_DISCARD = 3'd4
    } kind_t;

    typedef struct packed {
        logic [7:0]  data;
        kind_t       kind;
        logic        last;
        logic [31:0] frame_length;
    } result_t;

endpackage

### hdl/lpd_stream_if.sv
// Interfaces: the byte input channel and the result output channel.
interface lpd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface lpd_result_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic [2:0]  out_kind;
    logic        last;
    logic [31:0] frame_length;

    modport source (output valid, output out_byte, output out_kind, output last,
                    output frame_length, input ready);
    modport sink   (input valid, input out_byte, input out_kind, input last,
                    input frame_length, output ready);
endinterface

### hdl/lpd_core.sv
// Deframing state and the single-step update for one stream byte.
module lpd_core #(
    parameter int unsigned LENGTH_BYTES = lpd_pkg::LENGTH_BYTES_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  logic [7:0]       in_byte,
    input  logic             max_length_we,
    input  logic [31:0]      max_length_wdata,
    output lpd_pkg::result_t result
);
    import lpd_pkg::*;

    localparam int unsigned LEN_W = 8 * LENGTH_BYTES;
    localparam int unsigned CNT_W = (LENGTH_BYTES > 1) ? $clog2(LENGTH_BYTES) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(LENGTH_BYTES - 1);

    logic [31:0]      max_length_reg;
    logic [CNT_W-1:0] header_count_reg, header_count_next;
    logic [LEN_W-1:0] length_shift_reg, length_shift_next;
    logic [31:0]      bytes_left_reg, bytes_left_next;
    logic             in_payload_reg, in_payload_next;
    logic             failed_reg, failed_next;

    logic [LEN_W-1:0] shifted;
    logic [63:0]      len_ext;

    assign shifted = (length_shift_reg << 8) | LEN_W'(in_byte);
    assign len_ext = 64'(shifted);

    always_comb
    begin
        header_count_next = header_count_reg;
        length_shift_next = length_shift_reg;
        bytes_left_next   = bytes_left_reg;
        in_payload_next   = in_payload_reg;
        failed_next       = failed_reg;
        result            = '0;
        result.kind       = KIND_HEADER;

        if (failed_reg)
        begin
            result.kind = KIND_DISCARD;
        end
        else if (in_payload_reg)
        begin
            result.kind = KIND_PAYLOAD;
            result.data = in_byte;
            if (bytes_left_reg <= 32'd1)
            begin
                bytes_left_next = '0;
                in_payload_next = 1'b0;
                result.last     = 1'b1;
            end
            else
            begin
                bytes_left_next = bytes_left_reg - 32'd1;
            end
        end
        else if (header_count_reg != CNT_LAST)
        begin
            header_count_next = header_count_reg + CNT_W'(1);
            length_shift_next = shifted;
        end
        else
        begin
            header_count_next = '0;
            length_shift_next = '0;
            if (len_ext == 64'd0)
            begin
                result.kind = KIND_EMPTY;
            end
            else if (len_ext > {32'd0, max_length_reg})
            begin
                failed_next         = 1'b1;
                result.kind         = KIND_ERROR;
                result.frame_length = len_ext[31:0];
            end
            else
            begin
                bytes_left_next     = len_ext[31:0];
                in_payload_next     = 1'b1;
                result.frame_length = len_ext[31:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_length_reg   <= MAX_LENGTH_RESET;
            header_count_reg <= '0;
            length_shift_reg <= '0;
            bytes_left_reg   <= '0;
            in_payload_reg   <= 1'b0;
            failed_reg       <= 1'b0;
        end
        else
        begin
            if (max_length_we)
            begin
                max_length_reg <= max_length_wdata;
            end
            if (step)
            begin
                header_count_reg <= header_count_next;
                length_shift_reg <= length_shift_next;
                bytes_left_reg   <= bytes_left_next;
                in_payload_reg   <= in_payload_next;
                failed_reg       <= failed_next;
            end
        end
    end

endmodule

### hdl/lpd_out_reg.sv
// Result register driving the output channel.
module lpd_out_reg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  lpd_pkg::result_t    result,
    output logic                can_load,
    lpd_result_if.source        out_stream
);
    import lpd_pkg::*;

    logic    valid_reg;
    result_t result_reg;

    assign can_load = !valid_reg || out_stream.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (can_load)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (can_load && load)
        begin
            result_reg <= result;
        end
    end

    assign out_stream.valid        = valid_reg;
    assign out_stream.out_byte     = result_reg.data;
    assign out_stream.out_kind     = result_reg.kind;
    assign out_stream.last         = result_reg.last;
    assign out_stream.frame_length = result_reg.frame_length;

endmodule

### hdl/length_prefix_deframer.sv
// Top level of the length-prefix deframer.
//
// Receive side of a big-endian length-prefixed framing scheme. Each input
// beat carries one stream byte; each accepted byte yields exactly one result
// beat, registered in a single result register. LENGTH_BYTES
// header bytes (most significant first) form the frame length, which is
// shown on frame_length with the byte that completes the header. A zero
// length is reported as an empty frame and skipped. A length above
// max_length reports a length error, after which every byte is dropped as
// discarded until reset. Otherwise the next length bytes pass out as
// payload, the final one flagged last. Throughput is one byte per clock:
// in_stream.ready stays high as long as the result register is empty or is
// being drained in the same cycle, so only back-pressure on out_stream
// stalls the input. max_length resets to 65536 and should be written only
// while no beats are in flight.
module length_prefix_deframer #(
    parameter int unsigned LENGTH_BYTES = lpd_pkg::LENGTH_BYTES_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         max_length_we,
    input  logic [31:0]  max_length_wdata,
    lpd_byte_if.sink     in_stream,
    lpd_result_if.source out_stream
);
    import lpd_pkg::*;

    logic    can_load;
    logic    step;
    result_t result;

    // Take a byte whenever the result register can hold its outcome.
    assign in_stream.ready = can_load;
    assign step            = in_stream.valid && can_load;

    // Advance the deframing state and form the result for this byte.
    lpd_core #(
        .LENGTH_BYTES (LENGTH_BYTES)
    ) u_core (
        .clk              (clk),
        .rst_n            (rst_n),
        .step             (step),
        .in_byte          (in_stream.in_byte),
        .max_length_we    (max_length_we),
        .max_length_wdata (max_length_wdata),
        .result           (result)
    );

    // Hold the result until the downstream side takes it.
    lpd_out_reg u_out_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (step),
        .result     (result),
        .can_load   (can_load),
        .out_stream (out_stream)
    );

endmodule
